### src/ldfd_pkg.sv
// Shared types, constants and helpers for the LED fade dimmer controller.
package ldfd_pkg;

	localparam int NumBands = 6;
	localparam int BandWidth = 50;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	typedef logic [7:0] level_t;

	localparam level_t FULL_LEVEL = 8'd255;
	localparam level_t TOGGLE_THRESHOLD = 8'd250;
	localparam level_t STEP_RESET = 8'd1;
	localparam level_t MEDIUM_RESET = 8'd128;

	localparam logic [CfgIdxW-1:0] CFG_IDX_MEDIUM = CfgIdxW'(NumBands);

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_SET_TARGET = 3'd1,
		OP_ON_AT_MAX  = 3'd2,
		OP_TOGGLE_MAX = 3'd3,
		OP_TRIGGER    = 3'd4,
		OP_SET_MAX    = 3'd5,
		OP_OFF        = 3'd6,
		OP_SET_STATUS = 3'd7
	} opcode_t;

	typedef struct packed {
		logic   on_status;
		level_t max_level;
		level_t target_level;
		level_t duty_level;
	} dim_state_t;

	typedef struct packed {
		level_t [NumBands-1:0] step_band;
		level_t                medium_level;
	} dim_cfg_t;

	typedef struct packed {
		level_t duty;
		logic   is_on;
		logic   flag;
	} dim_result_t;

	// Band number is duty/50, clamped to the last band.
	function automatic logic [2:0] band_index(input level_t level);
		int count;
		count = 0;
		for (int k = 1; k < NumBands; k++) begin
			if (int'(level) >= k * BandWidth) begin
				count++;
			end
		end
		return 3'(count);
	endfunction

endpackage

### src/ldfd_in_if.sv
// Command channel carrying an opcode and its value.
interface ldfd_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

### src/ldfd_out_if.sv
// Result channel carrying the duty level, status and flag.
interface ldfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty;
	logic       is_on;
	logic       flag;

	modport source (output valid, output duty, output is_on, output flag, input ready);
	modport sink (input valid, input duty, input is_on, input flag, output ready);
endinterface

### src/ldfd_core.sv
// Next-state and result logic for one command or tick.
module ldfd_core
	import ldfd_pkg::*;
(
	input  dim_state_t  st,
	input  dim_cfg_t    cfg,
	input  logic [2:0]  opcode,
	input  level_t      value,
	output dim_state_t  nxt,
	output dim_result_t res
);

	logic [2:0] band;
	level_t     step;
	logic [8:0] reach;
	level_t     ramp_duty;
	logic       flag;

	always_comb begin
		band = band_index(st.duty_level);
		step = cfg.step_band[band];
		if (step == '0) begin
			step = 8'd1;
		end
		reach = {1'b0, st.duty_level} + {1'b0, step};
		// A step that would overshoot the target or underflow falls back to one,
		// so every decrease is a single count.
		if (step > st.duty_level || reach > {1'b0, st.target_level}) begin
			step = 8'd1;
		end
		if (st.duty_level < st.target_level) begin
			ramp_duty = st.duty_level + step;
		end else begin
			ramp_duty = st.duty_level - step;
		end
	end

	always_comb begin
		nxt  = st;
		flag = 1'b0;
		unique case (opcode_t'(opcode))
			OP_TICK: begin
				if (st.duty_level != st.target_level) begin
					nxt.duty_level = ramp_duty;
					flag = 1'b1;
				end
			end
			OP_SET_TARGET: begin
				nxt.target_level = value;
			end
			OP_ON_AT_MAX: begin
				if (!st.on_status) begin
					nxt.max_level    = FULL_LEVEL;
					nxt.target_level = FULL_LEVEL;
					nxt.on_status    = 1'b1;
					flag = 1'b1;
				end
			end
			OP_TOGGLE_MAX: begin
				nxt.target_level = (st.target_level > TOGGLE_THRESHOLD) ?
					cfg.medium_level : FULL_LEVEL;
				nxt.on_status = 1'b1;
			end
			OP_TRIGGER: begin
				if (st.on_status) begin
					nxt.target_level = '0;
					nxt.on_status    = 1'b0;
				end else begin
					nxt.target_level = cfg.medium_level;
					nxt.on_status    = 1'b1;
				end
				flag = !st.on_status;
			end
			OP_SET_MAX: begin
				nxt.max_level = value;
				if (st.on_status) begin
					nxt.target_level = value;
				end
			end
			OP_OFF: begin
				nxt.on_status    = 1'b0;
				nxt.max_level    = cfg.medium_level;
				nxt.target_level = '0;
			end
			OP_SET_STATUS: begin
				nxt.on_status    = value[0];
				nxt.target_level = value[0] ? st.max_level : '0;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

	assign res.duty  = nxt.duty_level;
	assign res.is_on = nxt.on_status;
	assign res.flag  = flag;

endmodule

### src/ldfd_skid.sv
// Two-entry output stage: result register with a skid register behind it.
module ldfd_skid
	import ldfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dim_result_t   push_data,
	output logic          push_ready,
	ldfd_out_if.source    res
);

	logic        main_valid_q;
	logic        skid_valid_q;
	dim_result_t main_q;
	dim_result_t skid_q;
	logic        pop;

	assign pop        = main_valid_q && res.ready;
	assign push_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (push && main_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	assign res.valid = main_valid_q;
	assign res.duty  = main_q.duty;
	assign res.is_on = main_q.is_on;
	assign res.flag  = main_q.flag;

endmodule

### src/led_fade_dimmer_controller.sv
// LED fade dimmer controller: state and step registers, update logic and output stage.
// A result enters the output stage at the clock edge of its command transfer.
// Throughput: one command or tick per cycle while the skid register is free;
// the two-entry output stage keeps the input open while one result waits.
// Reset: arst_n clears the dimmer off with maximum 255, target and duty 0,
// band steps 1 and medium level 128; the output stage empties.
module led_fade_dimmer_controller
	import ldfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	ldfd_in_if.sink             cmd,
	ldfd_out_if.source          res
);

	dim_state_t  state_q;
	dim_state_t  state_nxt;
	dim_cfg_t    cfg_q;
	dim_result_t result;
	logic        accept;
	logic        stage_ready;

	assign cmd.ready = stage_ready;
	assign accept    = cmd.valid && stage_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_band    <= {NumBands{STEP_RESET}};
			cfg_q.medium_level <= MEDIUM_RESET;
		end else if (cfg_we) begin
			if (cfg_index < CFG_IDX_MEDIUM) begin
				cfg_q.step_band[cfg_index] <= cfg_wdata;
			end else if (cfg_index == CFG_IDX_MEDIUM) begin
				cfg_q.medium_level <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.on_status    <= 1'b0;
			state_q.max_level    <= FULL_LEVEL;
			state_q.target_level <= '0;
			state_q.duty_level   <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	ldfd_core u_core (
		.st     (state_q),
		.cfg    (cfg_q),
		.opcode (cmd.opcode),
		.value  (cmd.value),
		.nxt    (state_nxt),
		.res    (result)
	);

	ldfd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (result),
		.push_ready (stage_ready),
		.res        (res)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED fade dimmer controller: directed and random commands.
module tb;
	import ldfd_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	ldfd_in_if  cmd_if ();
	ldfd_out_if res_if ();

	led_fade_dimmer_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.res       (res_if)
	);

	dim_state_t  dimmer_state;
	dim_cfg_t    dimmer_cfg;
	dim_result_t expected_results[$];
	dim_result_t oldest_result;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned items_sent = 0;
	bit          steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result of one command or tick and advances the dimmer state.
	function automatic dim_result_t predict_result(input opcode_t op, input level_t val);
		dim_result_t r;
		int          duty;
		int          target;
		int          stride;
		int          band;
		r.flag = 1'b0;
		case (op)
			OP_TICK: begin
				duty   = dimmer_state.duty_level;
				target = dimmer_state.target_level;
				if (duty != target) begin
					band = duty / BandWidth;
					if (band > NumBands - 1) begin
						band = NumBands - 1;
					end
					stride = dimmer_cfg.step_band[band];
					if (stride == 0) begin
						stride = 1;
					end
					// A step that would pass the target or fall below zero shrinks to one.
					if (stride > duty || duty + stride > target) begin
						stride = 1;
					end
					duty = (duty < target) ? duty + stride : duty - stride;
					dimmer_state.duty_level = level_t'(duty);
					r.flag = 1'b1;
				end
			end
			OP_SET_TARGET: dimmer_state.target_level = val;
			OP_ON_AT_MAX: begin
				if (!dimmer_state.on_status) begin
					dimmer_state.max_level    = FULL_LEVEL;
					dimmer_state.target_level = FULL_LEVEL;
					dimmer_state.on_status    = 1'b1;
					r.flag = 1'b1;
				end
			end
			OP_TOGGLE_MAX: begin
				dimmer_state.target_level = (dimmer_state.target_level > TOGGLE_THRESHOLD) ?
					dimmer_cfg.medium_level : FULL_LEVEL;
				dimmer_state.on_status = 1'b1;
			end
			OP_TRIGGER: begin
				if (dimmer_state.on_status) begin
					dimmer_state.target_level = '0;
					dimmer_state.on_status    = 1'b0;
				end else begin
					dimmer_state.target_level = dimmer_cfg.medium_level;
					dimmer_state.on_status    = 1'b1;
				end
				r.flag = dimmer_state.on_status;
			end
			OP_SET_MAX: begin
				dimmer_state.max_level = val;
				if (dimmer_state.on_status) begin
					dimmer_state.target_level = val;
				end
			end
			OP_OFF: begin
				dimmer_state.on_status    = 1'b0;
				dimmer_state.max_level    = dimmer_cfg.medium_level;
				dimmer_state.target_level = '0;
			end
			default: begin
				dimmer_state.on_status    = val[0];
				dimmer_state.target_level = val[0] ? dimmer_state.max_level : '0;
			end
		endcase
		r.duty  = dimmer_state.duty_level;
		r.is_on = dimmer_state.on_status;
		return r;
	endfunction

	// Sends one item, with an occasional gap before it, and records its expected result.
	task automatic send_cmd(input opcode_t op, input level_t val);
		if (!steady && $urandom_range(99) < 22) begin
			cmd_if.valid  <= 1'b0;
			cmd_if.opcode <= 3'($urandom_range(7));
			cmd_if.value  <= 8'($urandom_range(255));
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		cmd_if.valid  <= 1'b1;
		cmd_if.opcode <= op;
		cmd_if.value  <= val;
		// Inputs only change at rising edges, so the falling edge shows what the next edge sees.
		do @(negedge clk); while (!cmd_if.ready);
		expected_results.push_back(predict_result(op, val));
		items_sent++;
		@(posedge clk);
	endtask

	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_config(input dim_cfg_t cfg);
		int b;
		settle();
		for (b = 0; b < NumBands; b++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CfgIdxW'(b);
			cfg_wdata <= cfg.step_band[b];
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_MEDIUM;
		cfg_wdata <= cfg.medium_level;
		@(posedge clk);
		cfg_we     <= 1'b0;
		dimmer_cfg = cfg;
	endtask

	// Mostly a command that sets a target followed by a run of ticks, with some lone noise items.
	task automatic run_random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned ticks;
		level_t      val;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			val = 8'($urandom_range(255));
			if ($urandom_range(99) < 70) begin
				case ($urandom_range(4))
					0: send_cmd(OP_SET_TARGET, val);
					1: send_cmd(OP_TOGGLE_MAX, val);
					2: send_cmd(OP_ON_AT_MAX, val);
					3: send_cmd(OP_SET_STATUS, val | 8'h01);
					default: send_cmd(OP_TRIGGER, val);
				endcase
				ticks = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(4, 40);
				repeat (ticks) send_cmd(OP_TICK, 8'($urandom_range(255)));
			end else begin
				send_cmd(opcode_t'($urandom_range(7)), val);
			end
		end
	endtask

	task automatic test_commands();
		send_cmd(OP_TICK, 8'h00);
		send_cmd(OP_SET_STATUS, 8'hFE);
		send_cmd(OP_SET_STATUS, 8'h01);
		send_cmd(OP_TICK, 8'hFF);
		send_cmd(OP_SET_MAX, 8'h00);
		send_cmd(OP_TICK, 8'h00);
		send_cmd(OP_SET_MAX, 8'hFF);
		send_cmd(OP_ON_AT_MAX, 8'h00);
		send_cmd(OP_OFF, 8'hFF);
		send_cmd(OP_ON_AT_MAX, 8'hFF);
		send_cmd(OP_TOGGLE_MAX, 8'h00);
		send_cmd(OP_TOGGLE_MAX, 8'hFF);
		send_cmd(OP_TRIGGER, 8'hAA);
		send_cmd(OP_TRIGGER, 8'h55);
		send_cmd(OP_SET_TARGET, 8'hFF);
		send_cmd(OP_TICK, 8'h00);
		send_cmd(OP_TICK, 8'h00);
		send_cmd(OP_SET_TARGET, 8'h00);
		send_cmd(OP_TICK, 8'hFF);
		send_cmd(OP_TICK, 8'hFF);
		send_cmd(OP_OFF, 8'h00);
		send_cmd(OP_SET_MAX, 8'h00);
		send_cmd(OP_SET_STATUS, 8'hFF);
		send_cmd(OP_TICK, 8'h00);
	endtask

	task automatic test_reset_steps();
		run_random_traffic(220);
	endtask

	task automatic test_full_steps();
		dim_cfg_t cfg;
		cfg.step_band    = {NumBands{8'hFF}};
		cfg.medium_level = 8'hFF;
		load_config(cfg);
		run_random_traffic(220);
	endtask

	// A zero band step behaves as a step of one.
	task automatic test_zero_steps();
		dim_cfg_t cfg;
		cfg.step_band    = '0;
		cfg.medium_level = 8'h00;
		load_config(cfg);
		run_random_traffic(220);
	endtask

	task automatic test_moderate_steps_back_to_back();
		dim_cfg_t cfg;
		int       b;
		for (b = 0; b < NumBands; b++) begin
			cfg.step_band[b] = 8'($urandom_range(2, 40));
		end
		cfg.medium_level = 8'($urandom_range(255));
		load_config(cfg);
		steady = 1'b1;
		run_random_traffic(260);
		steady = 1'b0;
	endtask

	task automatic test_random_steps();
		dim_cfg_t cfg;
		int       b;
		for (b = 0; b < NumBands; b++) begin
			cfg.step_band[b] = 8'($urandom_range(255));
		end
		cfg.medium_level = 8'($urandom_range(255));
		load_config(cfg);
		run_random_traffic(260);
	endtask

	always @(posedge clk) begin
		res_if.ready <= steady || ($urandom_range(99) >= 22);
	end

	always @(negedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: duty %0d is_on %0d flag %0d",
					res_if.duty, res_if.is_on, res_if.flag);
				error_count++;
			end else begin
				oldest_result = expected_results.pop_front();
				if (res_if.duty !== oldest_result.duty) begin
					$error("duty: expected %0d, got %0d", oldest_result.duty, res_if.duty);
					error_count++;
				end
				if (res_if.is_on !== oldest_result.is_on) begin
					$error("is_on: expected %0d, got %0d", oldest_result.is_on, res_if.is_on);
					error_count++;
				end
				if (res_if.flag !== oldest_result.flag) begin
					$error("flag: expected %0d, got %0d", oldest_result.flag, res_if.flag);
					error_count++;
				end
			end
		end
	end

	// Ends the run if no transfer happens on either channel for too long.
	always @(negedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= 2000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		cmd_if.valid  <= 1'b0;
		cmd_if.opcode <= OP_TICK;
		cmd_if.value  <= '0;
		dimmer_state.on_status       = 1'b0;
		dimmer_state.max_level       = FULL_LEVEL;
		dimmer_state.target_level    = '0;
		dimmer_state.duty_level      = '0;
		dimmer_cfg.step_band         = {NumBands{STEP_RESET}};
		dimmer_cfg.medium_level      = MEDIUM_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_reset_steps();
		test_full_steps();
		test_zero_steps();
		test_moderate_steps_back_to_back();
		test_random_steps();

		settle();
		repeat (5) @(posedge clk);
		if (error_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
